@@ hw/rtl/quadratic_probe_hash_map_macros.svh @@
// Assertion macros for the quadratic probe hash map.
// Included by the modules that carry concurrent checks; clocked by clk_i, disabled while rst_ni is low.
`ifndef QUADRATIC_PROBE_HASH_MAP_MACROS_SVH
`define QUADRATIC_PROBE_HASH_MAP_MACROS_SVH
`ifndef SYNTHESIS
`define QPHM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define QPHM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define QPHM_ASSERT(label, prop, msg)
`define QPHM_ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ hw/rtl/qphm_pkg.sv @@
// Types and constants of the quadratic probe hash map.
// No dependencies; imported by the top level.
package qphm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned PAY_W           = 32;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned USED_W          = 9;
  localparam int unsigned SLOT_W          = 2;
  localparam int unsigned WORD_W          = SLOT_W + KEY_W + PAY_W;
  // Step counter of the three-step home slot reduction.
  localparam int unsigned HASH_CNT_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_REMOVE = 2'd2
  } func_e;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } state_e;

endpackage

@@ hw/rtl/qphm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module qphm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/quadratic_probe_hash_map.sv @@
// Top level of the quadratic probe hash map: sequencer, probe arithmetic and result register.
// Depends on qphm_pkg, qphm_ram and quadratic_probe_hash_map_macros.svh.
//
// Usage:
// The input channel (in_valid_i/in_ready_o) takes one request word: func_i selects insert,
// lookup or remove, key_hash_i identifies the entry, payload_in_i is stored on insert.
// The output channel (out_valid_o/out_ready_i) returns one result word per request:
// found_o, payload_out_o, status_o and entries_used_o.
// All slot state, keys and payloads live in one RAM with a registered read. Probes are
// pipelined one per cycle: the next probe slot is read while the previous one is checked.
// With a power-of-two depth the home slot is a mask of the key. For other depths the home
// slot is formed by a byte fold, a reciprocal quotient estimate and one correcting
// subtract, done in the hash state before probing. A search ends on a key match, an empty
// slot or when all TableDepth probes are used. After reset the block clears the slot
// state, one entry per cycle, over all TableDepth entries with in_ready_o low. A result
// waits in the output register while the receiver stalls; the next request is still
// accepted and runs until it would need that register.
module quadratic_probe_hash_map #(
  parameter int unsigned TableDepth = qphm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [qphm_pkg::FUNC_W-1:0]   func_i,
  input  logic [qphm_pkg::KEY_W-1:0]    key_hash_i,
  input  logic [qphm_pkg::PAY_W-1:0]    payload_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [qphm_pkg::PAY_W-1:0]    payload_out_o,
  output logic [qphm_pkg::STATUS_W-1:0] status_o,
  output logic [qphm_pkg::USED_W-1:0]   entries_used_o
);

  import qphm_pkg::*;

  `include "quadratic_probe_hash_map_macros.svh"

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned SumW  = AddrW + 11;
  localparam bit          DepthPow2 = (TableDepth & (TableDepth - 1)) == 0;
  localparam logic [AddrW:0]      DepthExt = (AddrW + 1)'(TableDepth);
  localparam logic [CntW-1:0]     DepthCnt = CntW'(TableDepth);
  localparam logic [AddrW-1:0]    LastSlot = AddrW'(TableDepth - 1);
  localparam logic [HASH_CNT_W-1:0] LastHashStep = HASH_CNT_W'(2);
  localparam logic [SumW-1:0]     DepthSum = SumW'(TableDepth);
  localparam logic [31:0]         RecipM   = 32'((64'd1 << 32) / 64'(TableDepth));

  // Weight of key byte k modulo the depth.
  function automatic logic [AddrW-1:0] byte_weight(int unsigned k);
    return AddrW'((64'd1 << (8 * k)) % 64'(TableDepth));
  endfunction

  localparam logic [7:0][AddrW-1:0] ByteWeight = {
    byte_weight(7), byte_weight(6), byte_weight(5), byte_weight(4),
    byte_weight(3), byte_weight(2), byte_weight(1), byte_weight(0)
  };

  // Control registers.
  state_e                state_q, state_d;
  logic [AddrW-1:0]      clr_idx_q, clr_idx_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       pcnt_q, pcnt_d;
  logic [HASH_CNT_W-1:0] hcnt_q, hcnt_d;
  logic                  rd_pend_q, rd_pend_d;
  logic                  tomb_vld_q, tomb_vld_d;
  logic                  out_valid_q, out_valid_d;

  // Payload registers.
  logic [FUNC_W-1:0]     func_q, func_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [PAY_W-1:0]      pay_q, pay_d;
  logic [AddrW-1:0]      home_q, home_d;
  logic [SumW-1:0]       hash_sum_q, hash_sum_d;
  logic [SumW-1:0]       hash_quo_q, hash_quo_d;
  logic [AddrW-1:0]      sq_q, sq_d;
  logic [AddrW-1:0]      step_q, step_d;
  logic [AddrW-1:0]      chk_slot_q, chk_slot_d;
  logic [AddrW-1:0]      tomb_slot_q, tomb_slot_d;
  logic                  out_found_q, out_found_d;
  logic [PAY_W-1:0]      out_pay_q, out_pay_d;
  status_e               out_status_q, out_status_d;
  logic [CntW-1:0]       out_used_q, out_used_d;

  // RAM port.
  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  // Datapath signals.
  logic                  in_fire, out_free, out_load;
  logic [AddrW:0]        slot_sum, sq_sum, step_sum;
  logic [AddrW-1:0]      slot_cur, sq_nxt, step_nxt, hash_nxt;
  logic [SumW-1:0]       hash_fold, hash_rem;
  logic [63:0]           hash_prod;
  slot_e                 rd_slot;
  logic [KEY_W-1:0]      rd_key;
  logic [PAY_W-1:0]      rd_pay;
  logic                  key_hit, is_empty, is_tomb, exhausted, bad_func, done, issue;
  logic                  res_found;
  logic [PAY_W-1:0]      res_pay;
  status_e               res_status;
  logic                  res_we;
  logic [AddrW-1:0]      res_waddr;
  logic [WORD_W-1:0]     res_wdata;
  logic [CntW-1:0]       res_count;

  qphm_ram #(
    .Width (WORD_W),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_cur),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Probe slot: home plus i squared, both kept below the depth so one subtract wraps.
  always_comb begin
    slot_sum = {1'b0, home_q} + {1'b0, sq_q};
    slot_cur = (slot_sum >= DepthExt) ? AddrW'(slot_sum - DepthExt) : AddrW'(slot_sum);
    sq_sum   = {1'b0, sq_q} + {1'b0, step_q};
    sq_nxt   = (sq_sum >= DepthExt) ? AddrW'(sq_sum - DepthExt) : AddrW'(sq_sum);
    step_sum = {1'b0, step_q} + (AddrW + 1)'(2);
    step_nxt = (step_sum >= DepthExt) ? AddrW'(step_sum - DepthExt) : AddrW'(step_sum);
    // Each key byte is scaled by its weight modulo the depth, so the folded sum keeps the
    // remainder. The reciprocal estimate of the quotient is at most one short.
    hash_fold = '0;
    for (int k = 0; k < 8; k++) begin
      hash_fold = hash_fold + SumW'(key_q[8*k +: 8]) * SumW'(ByteWeight[k]);
    end
    hash_prod = 64'(hash_sum_q) * 64'(RecipM);
    hash_rem  = hash_sum_q - hash_quo_q * DepthSum;
    hash_nxt  = (hash_rem >= DepthSum) ? AddrW'(hash_rem - DepthSum) : AddrW'(hash_rem);
  end

  // Check of the word read for the previous probe.
  always_comb begin
    rd_slot   = slot_e'(ram_rdata[WORD_W-1 -: SLOT_W]);
    rd_key    = ram_rdata[PAY_W +: KEY_W];
    rd_pay    = ram_rdata[PAY_W-1:0];
    key_hit   = rd_pend_q && (rd_slot == SLOT_USED) && (rd_key == key_q);
    is_empty  = rd_pend_q && (rd_slot == SLOT_EMPTY);
    is_tomb   = rd_pend_q && (rd_slot != SLOT_EMPTY) && (rd_slot != SLOT_USED);
    exhausted = !rd_pend_q && (pcnt_q == DepthCnt);
    bad_func  = (func_q != FN_INSERT) && (func_q != FN_LOOKUP) && (func_q != FN_REMOVE);
    done      = (state_q == ST_PROBE) && (bad_func || key_hit || is_empty || exhausted);
    issue     = (state_q == ST_PROBE) && !done && (pcnt_q != DepthCnt);
    out_load  = done && out_free;
  end

  // Result and table update at the end of a request.
  always_comb begin
    res_found  = 1'b0;
    res_pay    = '0;
    res_status = STAT_MISS;
    res_we     = 1'b0;
    res_waddr  = chk_slot_q;
    res_wdata  = {SLOT_TOMB, {KEY_W{1'b0}}, {PAY_W{1'b0}}};
    res_count  = count_q;
    if (!bad_func) begin
      if (func_q == FN_INSERT) begin
        if (key_hit) begin
          res_status = STAT_DUP;
        end else if (is_empty || tomb_vld_q) begin
          // The first tombstone on the path wins over the empty slot.
          res_found  = 1'b1;
          res_status = STAT_OK;
          res_we     = 1'b1;
          res_waddr  = tomb_vld_q ? tomb_slot_q : chk_slot_q;
          res_wdata  = {SLOT_USED, key_q, pay_q};
          res_count  = count_q + CntW'(1);
        end
      end else if (key_hit) begin
        res_found  = 1'b1;
        res_status = STAT_OK;
        res_pay    = rd_pay;
        if (func_q == FN_REMOVE) begin
          res_we = 1'b1;
          if (count_q != '0) begin
            res_count = count_q - CntW'(1);
          end
        end
      end
    end
  end

  // RAM port selection.
  always_comb begin
    ram_re    = issue;
    ram_we    = 1'b0;
    ram_waddr = res_waddr;
    ram_wdata = res_wdata;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = {SLOT_EMPTY, {KEY_W{1'b0}}, {PAY_W{1'b0}}};
    end else if (out_load) begin
      ram_we = res_we;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = DepthPow2 ? ST_PROBE : ST_HASH;
        end
      end
      ST_HASH: begin
        if (hcnt_q == LastHashStep) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Register updates.
  always_comb begin
    clr_idx_d    = clr_idx_q;
    count_d      = count_q;
    pcnt_d       = pcnt_q;
    hcnt_d       = hcnt_q;
    rd_pend_d    = rd_pend_q;
    tomb_vld_d   = tomb_vld_q;
    func_d       = func_q;
    key_d        = key_q;
    pay_d        = pay_q;
    home_d       = home_q;
    hash_sum_d   = hash_sum_q;
    hash_quo_d   = hash_quo_q;
    sq_d         = sq_q;
    step_d       = step_q;
    chk_slot_d   = chk_slot_q;
    tomb_slot_d  = tomb_slot_q;
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_pay_d    = out_pay_q;
    out_status_d = out_status_q;
    out_used_d   = out_used_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + AddrW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          func_d     = func_i;
          key_d      = key_hash_i;
          pay_d      = payload_in_i;
          home_d     = DepthPow2 ? key_hash_i[AddrW-1:0] : '0;
          hcnt_d     = '0;
          sq_d       = '0;
          step_d     = AddrW'(1);
          pcnt_d     = '0;
          rd_pend_d  = 1'b0;
          tomb_vld_d = 1'b0;
        end
      end
      ST_HASH: begin
        // Fold, then quotient estimate, then the corrected remainder.
        hash_sum_d = hash_fold;
        hash_quo_d = SumW'(hash_prod[63:32]);
        hcnt_d     = hcnt_q + HASH_CNT_W'(1);
        if (hcnt_q == LastHashStep) begin
          home_d = hash_nxt;
        end
      end
      ST_PROBE: begin
        if (out_load) begin
          rd_pend_d    = 1'b0;
          count_d      = res_count;
          out_valid_d  = 1'b1;
          out_found_d  = res_found;
          out_pay_d    = res_pay;
          out_status_d = res_status;
          out_used_d   = res_count;
        end else if (!done) begin
          rd_pend_d = issue;
          if (issue) begin
            sq_d       = sq_nxt;
            step_d     = step_nxt;
            pcnt_d     = pcnt_q + CntW'(1);
            chk_slot_d = slot_cur;
          end
          if (is_tomb && !tomb_vld_q) begin
            tomb_vld_d  = 1'b1;
            tomb_slot_d = chk_slot_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      count_q     <= '0;
      pcnt_q      <= '0;
      hcnt_q      <= '0;
      rd_pend_q   <= 1'b0;
      tomb_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      pcnt_q      <= pcnt_d;
      hcnt_q      <= hcnt_d;
      rd_pend_q   <= rd_pend_d;
      tomb_vld_q  <= tomb_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    home_q       <= home_d;
    hash_sum_q   <= hash_sum_d;
    hash_quo_q   <= hash_quo_d;
    sq_q         <= sq_d;
    step_q       <= step_d;
    chk_slot_q   <= chk_slot_d;
    tomb_slot_q  <= tomb_slot_d;
    out_found_q  <= out_found_d;
    out_pay_q    <= out_pay_d;
    out_status_q <= out_status_d;
    out_used_q   <= out_used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign payload_out_o  = out_pay_q;
  assign status_o       = out_status_q;
  assign entries_used_o = USED_W'(out_used_q);

  `QPHM_ASSERT_NEVER(a_count_over_depth, count_q > DepthCnt, "entry count exceeds table depth")
  `QPHM_ASSERT(a_probe_write_has_result, (state_q == ST_PROBE && ram_we) |-> out_load,
    "table written during probing without a result word")
  `QPHM_ASSERT(a_accept_starts_work, in_fire |=> !in_ready_o,
    "input still ready right after a word was accepted")
  `QPHM_ASSERT(a_clear_only_after_reset, (state_q != ST_CLEAR) |=> (state_q != ST_CLEAR),
    "clearing pass restarted outside reset")

endmodule

@@ dv/qphm_result_checker.sv @@
// Result checker for the quadratic probe hash map: mirrors the table from accepted requests
// and compares every returned word with the predicted outcome, field by field.
// Depends on qphm_pkg.
module qphm_result_checker
  import qphm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [KEY_W-1:0]    key_hash_i,
  input  logic [PAY_W-1:0]    payload_in_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                found_i,
  input  logic [PAY_W-1:0]    payload_out_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [USED_W-1:0]   entries_used_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned Depth = TABLE_DEPTH_DEF;
  localparam int unsigned PrintCap = 200;

  typedef struct packed {
    logic              found;
    logic [PAY_W-1:0]  payload;
    status_e           status;
    logic [USED_W-1:0] used;
  } outcome_t;

  logic [KEY_W-1:0]  key_tbl  [Depth];
  logic [PAY_W-1:0]  pay_tbl  [Depth];
  slot_e             slot_tbl [Depth];
  logic [USED_W-1:0] occupied;
  outcome_t          pending_outcomes [$];
  int unsigned       mismatches = 0;
  int unsigned       words_seen = 0;

  function automatic int unsigned probe_slot_at(int unsigned home, int unsigned step);
    return (home + (step * step) % Depth) % Depth;
  endfunction

  function automatic int unsigned home_of(logic [KEY_W-1:0] key);
    return int'(key % Depth);
  endfunction

  // Returns the slot holding the key, or Depth when the search ends without a hit.
  function automatic int unsigned locate(logic [KEY_W-1:0] key);
    int unsigned s;
    for (int unsigned i = 0; i < Depth; i++) begin
      s = probe_slot_at(home_of(key), i);
      if (slot_tbl[s] == SLOT_EMPTY) return Depth;
      if (slot_tbl[s] == SLOT_USED && key_tbl[s] == key) return s;
    end
    return Depth;
  endfunction

  // Applies one request to the mirrored table and returns the word it should produce.
  function automatic outcome_t apply_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                                             logic [PAY_W-1:0] pay);
    outcome_t    res;
    int unsigned s;
    int unsigned tomb;
    int unsigned target;
    logic        dup;
    res.found   = 1'b0;
    res.payload = '0;
    res.status  = STAT_MISS;
    tomb        = Depth;
    target      = Depth;
    dup         = 1'b0;
    if (fn == FN_INSERT) begin
      for (int unsigned i = 0; i < Depth; i++) begin
        s = probe_slot_at(home_of(key), i);
        if (slot_tbl[s] == SLOT_EMPTY) begin
          target = s;
          break;
        end
        if (slot_tbl[s] == SLOT_USED) begin
          if (key_tbl[s] == key) begin
            dup = 1'b1;
            break;
          end
        end else if (tomb == Depth) begin
          tomb = s;
        end
      end
      if (dup) begin
        res.status = STAT_DUP;
      end else begin
        // The first tombstone on the probe path wins over a later empty slot.
        if (tomb != Depth) target = tomb;
        if (target != Depth) begin
          key_tbl[target]  = key;
          pay_tbl[target]  = pay;
          slot_tbl[target] = SLOT_USED;
          occupied++;
          res.found  = 1'b1;
          res.status = STAT_OK;
        end
      end
    end else if (fn == FN_LOOKUP || fn == FN_REMOVE) begin
      s = locate(key);
      if (s != Depth) begin
        res.found   = 1'b1;
        res.status  = STAT_OK;
        res.payload = pay_tbl[s];
        if (fn == FN_REMOVE) begin
          slot_tbl[s] = SLOT_TOMB;
          if (occupied != 0) occupied--;
        end
      end
    end
    res.used = occupied;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PrintCap)
      $display("%0t: word %0d: %s is 0x%0h, predicted 0x%0h", $time, words_seen, field,
               got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < Depth; i++) slot_tbl[i] = SLOT_EMPTY;
      occupied = '0;
      pending_outcomes.delete();
    end else begin
      // The result of a request accepted at this edge cannot leave at the same edge,
      // so the returned word is checked before the new request is predicted.
      if (out_valid_i && out_ready_i) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unexpected word, payload", 64'(payload_out_i), '0);
        end else begin
          want = pending_outcomes.pop_front();
          if (found_i !== want.found)
            report_mismatch("found", 64'(found_i), 64'(want.found));
          if (payload_out_i !== want.payload)
            report_mismatch("payload_out", 64'(payload_out_i), 64'(want.payload));
          if (status_i !== want.status)
            report_mismatch("status", 64'(status_i), 64'(want.status));
          if (entries_used_i !== want.used)
            report_mismatch("entries_used", 64'(entries_used_i), 64'(want.used));
        end
        words_seen++;
      end
      if (in_valid_i && in_ready_i)
        pending_outcomes.push_back(apply_request(func_i, key_hash_i, payload_in_i));
    end
    mismatch_count_o <= mismatches;
    pending_o        <= pending_outcomes.size();
  end

endmodule

@@ dv/quadratic_probe_hash_map_test.sv @@
// Testbench top for the quadratic probe hash map: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on qphm_pkg, quadratic_probe_hash_map
// and qphm_result_checker.
module quadratic_probe_hash_map_test;
  import qphm_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int unsigned KeyPool    = 48;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned Depth      = TABLE_DEPTH_DEF;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   func = '0;
  logic [KEY_W-1:0]    key_hash = '0;
  logic [PAY_W-1:0]    payload_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                found;
  logic [PAY_W-1:0]    payload_out;
  logic [STATUS_W-1:0] status;
  logic [USED_W-1:0]   entries_used;
  int unsigned         mismatch_count;
  int unsigned         pending;

  bit                  brisk = 1'b0;
  int unsigned         holds_asked = 0;
  logic [KEY_W-1:0]    key_pool  [KeyPool];
  logic [KEY_W-1:0]    fill_keys [Depth];

  quadratic_probe_hash_map uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .key_hash_i     (key_hash),
    .payload_in_i   (payload_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .found_o        (found),
    .payload_out_o  (payload_out),
    .status_o       (status),
    .entries_used_o (entries_used)
  );

  qphm_result_checker result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .func_i           (func),
    .key_hash_i       (key_hash),
    .payload_in_i     (payload_in),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .found_i          (found),
    .payload_out_i    (payload_out),
    .status_i         (status),
    .entries_used_i   (entries_used),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return FN_INSERT;
    if (r < 70) return FN_LOOKUP;
    if (r < 95) return FN_REMOVE;
    return FN_UNUSED;
  endfunction

  task automatic submit(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                        input logic [PAY_W-1:0] pay);
    int unsigned gap;
    gap = brisk ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    key_hash   <= key;
    payload_in <= pay;
    do @(posedge clk); while (!in_ready);
  endtask

  // Keys 0, 256 and 512 share home slot 0, so they exercise collisions and tombstones.
  task automatic run_directed();
    submit(FN_INSERT, 64'd0, 32'd0);
    submit(FN_INSERT, '1, '1);
    submit(FN_LOOKUP, 64'd0, 32'hDEAD_BEEF);
    submit(FN_LOOKUP, '1, 32'd0);
    submit(FN_INSERT, 64'd0, 32'd5);
    submit(FN_INSERT, 64'd256, 32'hA5A5_A5A5);
    submit(FN_LOOKUP, 64'd256, '0);
    submit(FN_LOOKUP, 64'd512, '0);
    submit(FN_REMOVE, 64'd0, '0);
    submit(FN_REMOVE, 64'd0, '0);
    submit(FN_LOOKUP, 64'd256, '0);
    submit(FN_INSERT, 64'd512, 32'h0000_FFFF);
    submit(FN_LOOKUP, 64'd512, '0);
    submit(FN_UNUSED, 64'd256, '1);
    submit(FN_LOOKUP, 64'd256, '0);
    submit(FN_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    submit(FN_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    submit(FN_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    submit(FN_LOOKUP, 64'h5555_5555_5555_5555, '0);
    submit(FN_REMOVE, '1, '0);
    submit(FN_REMOVE, 64'd256, '0);
    submit(FN_REMOVE, 64'd512, '0);
  endtask

  task automatic run_mixed(input int unsigned count);
    logic [KEY_W-1:0] key;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) key = random_key();
      else key = key_pool[$urandom_range(0, KeyPool - 1)];
      submit(pick_op(), key, $urandom);
    end
  endtask

  // A single home slot only reaches the quadratic residues, far fewer than the depth,
  // so a long run of inserts there exhausts its probes.
  task automatic run_cluster();
    logic [7:0]       home;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] members [56];
    home = 8'($urandom);
    for (int n = 0; n < 56; n++) begin
      members[n] = random_key();
      members[n][7:0] = home;
      submit(FN_INSERT, members[n], $urandom);
    end
    for (int n = 0; n < 6; n++) begin
      key = random_key();
      key[7:0] = home;
      submit(FN_LOOKUP, key, $urandom);
    end
    for (int n = 0; n < 12; n++) submit(FN_REMOVE, members[$urandom_range(0, 55)], $urandom);
    for (int n = 0; n < 12; n++) begin
      key = random_key();
      key[7:0] = home;
      submit(FN_INSERT, key, $urandom);
    end
    for (int n = 0; n < 12; n++) submit(pick_op(), members[$urandom_range(0, 55)], $urandom);
  endtask

  // One fresh key is inserted per home slot to fill the table; the table is then worked
  // and finally the fill keys are removed again, which leaves tombstones behind.
  task automatic run_fill_and_drain();
    logic [KEY_W-1:0] key;
    for (int j = 0; j < Depth; j++) begin
      fill_keys[j] = random_key();
      fill_keys[j][7:0] = 8'(j);
      submit(FN_INSERT, fill_keys[j], $urandom);
    end
    for (int n = 0; n < 8; n++) submit(FN_INSERT, random_key(), $urandom);
    for (int n = 0; n < 8; n++) submit(FN_LOOKUP, random_key(), $urandom);
    for (int n = 0; n < 8; n++)
      submit(FN_LOOKUP, fill_keys[$urandom_range(0, Depth - 1)], $urandom);
    for (int n = 0; n < 10; n++)
      submit(FN_REMOVE, fill_keys[$urandom_range(0, Depth - 1)], $urandom);
    for (int n = 0; n < 10; n++) begin
      key = random_key();
      submit(FN_INSERT, key, $urandom);
    end
    for (int n = 0; n < 6; n++)
      submit(FN_INSERT, fill_keys[$urandom_range(0, Depth - 1)], $urandom);
    for (int j = 0; j < Depth; j++) submit(FN_REMOVE, fill_keys[j], $urandom);
  endtask

  initial begin : drain_results
    int unsigned stall;
    int unsigned holds_done;
    holds_done = 0;
    @(posedge clk);
    forever begin
      stall = brisk ? 0 : $urandom_range(0, 7);
      if (holds_asked != holds_done) begin
        holds_done = holds_asked;
        stall = LongHold;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Half the pool shares four home slots so that collisions are common.
    for (int j = 0; j < KeyPool; j++) begin
      key_pool[j] = random_key();
      if (j < KeyPool / 2) key_pool[j][7:0] = 8'h10 + 8'(j % 4);
    end
    run_directed();
    run_mixed(200);
    // Back-to-back words while the receiver holds off, so the block backs up.
    brisk = 1'b1;
    holds_asked++;
    run_mixed(80);
    brisk = 1'b0;
    run_mixed(100);
    run_cluster();
    run_fill_and_drain();
    run_mixed(100);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/qphm_pkg.sv
hw/rtl/qphm_ram.sv
hw/rtl/quadratic_probe_hash_map.sv
dv/qphm_result_checker.sv
dv/quadratic_probe_hash_map_test.sv
